[hdl/fla_pkg.sv]
`default_nettype none

package fla_pkg;

  // Link and index widths fixed by the slot numbering (at most 256 slots).
  localparam int LINK_W    = 9;
  localparam int IDX_W     = 8;
  localparam int MAX_SLOTS = 256;

  // Null link code: one past the highest possible slot.
  localparam logic [LINK_W-1:0] NULL_LINK = 9'd256;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes.
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage

`default_nettype wire

[hdl/fla_ram.sv]
`default_nettype none

module fla_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/free_list_slot_allocator.sv]
`default_nettype none

// Fixed-size slot pool kept as a LIFO free list. Raise start with cmd and
// slot_index while busy is low: an allocate pops the head slot and returns it
// on granted_index, or reports status empty when no slot is free; a free
// pushes slot_index back onto the head (a slot at or above the pool size is
// dropped, still reported as done). Every item gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it, so take
// it on that cycle. A free or a failed allocate shows its result in the cycle
// right after the accept edge, and the next item is accepted at the edge that
// ends it; a successful allocate first passes through ST_READ, since the link
// of the popped slot comes out of the registered link RAM only after its
// read, and busy stays high in ST_READ. Double frees are not checked. A write
// on cfg_write sets the pool
// size (saturated to min(256, DEPTH)) and rebuilds the list at once with the
// highest slot on top; write it only while the block is idle. Reset and
// rebuild need no clearing pass: one valid bit per slot marks links written
// since, and an unmarked slot reads as its initial link.

module free_list_slot_allocator #(
  parameter int DEPTH = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // command channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      cmd,
  input  wire logic [fla_pkg::IDX_W-1:0] slot_index,
  // result channel
  output logic                           done,
  output logic                           status,
  output logic      [fla_pkg::IDX_W-1:0] granted_index,
  // configuration
  input  wire logic                      cfg_write,
  input  wire logic [fla_pkg::LINK_W-1:0] cfg_data
);

  // Only slot numbers below 256 are reachable, so the RAM never needs more.
  localparam int SLOTS = (DEPTH < fla_pkg::MAX_SLOTS) ? DEPTH : fla_pkg::MAX_SLOTS;
  localparam int AW    = $clog2(SLOTS);
  localparam logic [fla_pkg::LINK_W-1:0] SLOTS_L = fla_pkg::LINK_W'(SLOTS);

  fla_pkg::state_t              state;
  logic [fla_pkg::LINK_W-1:0]   head;
  logic [fla_pkg::LINK_W-1:0]   count;
  logic [SLOTS-1:0]             valid;
  logic [AW-1:0]                alloc_slot;

  logic                         accept;
  logic                         head_empty;
  logic                         free_ok;
  logic [fla_pkg::LINK_W-1:0]   cfg_count;
  logic [fla_pkg::LINK_W-1:0]   slot_ext;
  logic [fla_pkg::LINK_W-1:0]   init_link;
  logic [fla_pkg::LINK_W-1:0]   next_head;

  logic                         ram_we;
  logic                         ram_re;
  logic [fla_pkg::LINK_W-1:0]   ram_rdata;

  assign busy       = (state == fla_pkg::ST_READ);
  assign accept     = start && !busy;
  assign head_empty = (head >= count);
  assign free_ok    = ({1'b0, slot_index} < count);
  assign cfg_count  = (cfg_data > SLOTS_L) ? SLOTS_L : cfg_data;

  // Push writes the old head into the freed slot; pop reads the head's link.
  assign ram_we = accept && (cmd == fla_pkg::CMD_FREE) && free_ok;
  assign ram_re = accept && (cmd == fla_pkg::CMD_ALLOC) && !head_empty;

  fla_ram #(
    .WIDTH (fla_pkg::LINK_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_index[AW-1:0]),
    .wdata (head),
    .re    (ram_re),
    .raddr (head[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Link a slot has after a rebuild: the slot below it, slot 0 to null.
  always_comb begin
    slot_ext  = fla_pkg::LINK_W'(alloc_slot);
    init_link = ((slot_ext != '0) && (slot_ext < count)) ? (slot_ext - 1'b1)
                                                        : fla_pkg::NULL_LINK;
    next_head = valid[alloc_slot] ? ram_rdata : init_link;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fla_pkg::ST_IDLE;
      count <= SLOTS_L;
      head  <= SLOTS_L - 1'b1;
      valid <= '0;
      done  <= 1'b0;
    end else if (cfg_write) begin
      // Rebuild: drop every written link, top of list is the highest slot.
      count <= cfg_count;
      head  <= (cfg_count == '0) ? fla_pkg::NULL_LINK : (cfg_count - 1'b1);
      valid <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        fla_pkg::ST_IDLE: begin
          if (accept) begin
            if (cmd == fla_pkg::CMD_FREE) begin
              done <= 1'b1;
              if (free_ok) begin
                head                     <= fla_pkg::LINK_W'(slot_index);
                valid[slot_index[AW-1:0]] <= 1'b1;
              end
            end else if (head_empty) begin
              done <= 1'b1;
            end else begin
              state <= fla_pkg::ST_READ;
            end
          end
        end
        fla_pkg::ST_READ: begin
          // Advance the head to the popped slot's link.
          head  <= next_head;
          done  <= 1'b1;
          state <= fla_pkg::ST_IDLE;
        end
        default: begin
          state <= fla_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == fla_pkg::ST_READ) begin
      status        <= fla_pkg::STATUS_DONE;
      granted_index <= fla_pkg::IDX_W'(alloc_slot);
    end else if (accept) begin
      alloc_slot    <= head[AW-1:0];
      granted_index <= '0;
      status        <= ((cmd == fla_pkg::CMD_ALLOC) && head_empty) ? fla_pkg::STATUS_EMPTY
                                                                   : fla_pkg::STATUS_DONE;
    end
  end

endmodule

`default_nettype wire

[bench/slot_grant_checker.sv]
`timescale 1ns / 100ps

module slot_grant_checker #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic                       cmd,
  input  wire logic [fla_pkg::IDX_W-1:0]  slot_index,
  input  wire logic                       done,
  input  wire logic                       status,
  input  wire logic [fla_pkg::IDX_W-1:0]  granted_index,
  input  wire logic                       cfg_write,
  input  wire logic [fla_pkg::LINK_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              open_results
);

  typedef struct packed {
    logic                      status;
    logic [fla_pkg::IDX_W-1:0] index;
  } grant_t;

  // Shadow copy of the free list.
  logic [fla_pkg::LINK_W-1:0] link_ram [fla_pkg::MAX_SLOTS];
  logic [fla_pkg::LINK_W-1:0] head;
  int unsigned                slots;
  grant_t                     grants_due [$];

  function automatic void reload_pool(input logic [fla_pkg::LINK_W-1:0] entries);
    int unsigned n;
    n = entries;
    if (n > fla_pkg::MAX_SLOTS) n = fla_pkg::MAX_SLOTS;
    if (n > DEPTH) n = DEPTH;
    slots = n;
    for (int i = 0; i < fla_pkg::MAX_SLOTS; i++) begin
      link_ram[i] = (i >= 1 && i < n) ? fla_pkg::LINK_W'(i - 1) : fla_pkg::NULL_LINK;
    end
    head = (n == 0) ? fla_pkg::NULL_LINK : fla_pkg::LINK_W'(n - 1);
  endfunction

  function automatic grant_t take_request(input logic op,
                                          input logic [fla_pkg::IDX_W-1:0] idx);
    grant_t g;
    g.status = fla_pkg::STATUS_DONE;
    g.index  = '0;
    if (op == fla_pkg::CMD_ALLOC) begin
      if (head >= slots) begin
        g.status = fla_pkg::STATUS_EMPTY;
      end else begin
        g.index = head[fla_pkg::IDX_W-1:0];
        head    = link_ram[head];
      end
    end else if (idx < slots) begin
      // out-of-range frees are dropped; double frees are pushed again
      link_ram[idx] = head;
      head          = {1'b0, idx};
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      reload_pool(fla_pkg::LINK_W'(fla_pkg::MAX_SLOTS));
      grants_due.delete();
    end else begin
      if (cfg_write) reload_pool(cfg_data);
      if (start && !busy) grants_due.push_back(take_request(cmd, slot_index));
      if (done) begin
        if (grants_due.size() == 0) begin
          fail_count++;
          $error("result with no item outstanding: status %0d, granted_index %0d",
                 status, granted_index);
        end else begin
          want = grants_due.pop_front();
          if (status !== want.status) begin
            fail_count++;
            $error("status mismatch: expected %0d, got %0d", want.status, status);
          end
          if (granted_index !== want.index) begin
            fail_count++;
            $error("granted_index mismatch: expected %0d, got %0d",
                   want.index, granted_index);
          end
        end
      end
    end
    open_results = grants_due.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH      = 256;
  localparam int LIMIT      = 200000;  // cycles before the hard stop
  localparam int PHASES     = 14;
  localparam int PHASE_LEN  = 48;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       cmd;
  logic [fla_pkg::IDX_W-1:0]  slot_index;
  logic                       done;
  logic                       status;
  logic [fla_pkg::IDX_W-1:0]  granted_index;
  logic                       cfg_write;
  logic [fla_pkg::LINK_W-1:0] cfg_data;

  int fail_count;
  int open_results;
  int cycles;
  int pool_size;

  // Commands in flight, oldest first, and slots currently handed out. The held
  // list lets the random part free mostly slots it owns, so the pool really
  // fills and drains instead of looping on double frees.
  logic                      inflight [$];
  logic [fla_pkg::IDX_W-1:0] held [$];

  free_list_slot_allocator #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .done         (done),
    .status       (status),
    .granted_index(granted_index),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  slot_grant_checker #(
    .DEPTH(DEPTH)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .done         (done),
    .status       (status),
    .granted_index(granted_index),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop in case the block hangs with busy high or drops results.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Follow accepts and results to keep the held list current.
  always @(posedge clk) begin : track
    logic op;
    if (!rst) begin
      if (start && !busy) inflight.push_back(cmd);
      if (done && inflight.size() != 0) begin
        op = inflight.pop_front();
        if (op == fla_pkg::CMD_ALLOC && status == fla_pkg::STATUS_DONE) begin
          held.push_back(granted_index);
        end
      end
    end
  end

  // Present one item after a gap of idle cycles and hold it until accepted.
  // Return right after the accepting edge with start still high, so a
  // back-to-back item replaces it at the next falling edge without a dip.
  task automatic issue(input logic op, input logic [fla_pkg::IDX_W-1:0] idx,
                       input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    cmd        = op;
    slot_index = idx;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every issued item has produced its result,
  // then let the block settle before returning.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (inflight.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Resize the pool while idle; the list is rebuilt, so nothing is held.
  task automatic write_pool(input logic [fla_pkg::LINK_W-1:0] entries);
    drain();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = entries;
    @(negedge clk);
    cfg_write = 1'b0;
    held.delete();
    pool_size = (entries > fla_pkg::MAX_SLOTS) ? fla_pkg::MAX_SLOTS : entries;
  endtask

  initial begin : stimulus
    int                        sizes [PHASES];
    int                        gap;
    int                        r;
    int                        pick;
    bit                        burst;
    logic                      op;
    logic [fla_pkg::IDX_W-1:0] idx;

    rst        = 1'b1;
    start      = 1'b0;
    cmd        = fla_pkg::CMD_ALLOC;
    slot_index = '0;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    pool_size  = fla_pkg::MAX_SLOTS;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Full pool out of reset: pop the top, push back, double frees, and
    // alternating bit patterns on slot_index.
    issue(fla_pkg::CMD_ALLOC, 8'd255, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);
    issue(fla_pkg::CMD_FREE, 8'd255, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 2);
    issue(fla_pkg::CMD_FREE, 8'd0, 0);     // slot 0 was never handed out
    issue(fla_pkg::CMD_ALLOC, 8'd170, 1);
    issue(fla_pkg::CMD_FREE, 8'd170, 0);
    issue(fla_pkg::CMD_FREE, 8'd85, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd85, 0);

    // Empty pool: every allocate fails, every free is out of range.
    write_pool(9'd0);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);
    issue(fla_pkg::CMD_FREE, 8'd0, 0);
    issue(fla_pkg::CMD_FREE, 8'd255, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd255, 3);

    // Single slot: grant, run dry, reject an out-of-range free, double free.
    write_pool(9'd1);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);
    issue(fla_pkg::CMD_FREE, 8'd1, 0);
    issue(fla_pkg::CMD_FREE, 8'd0, 0);
    issue(fla_pkg::CMD_FREE, 8'd0, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);

    // Oversized counts saturate to the full pool.
    write_pool(9'd511);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);
    issue(fla_pkg::CMD_FREE, 8'd255, 0);
    write_pool(9'd300);
    issue(fla_pkg::CMD_ALLOC, 8'd0, 0);

    sizes = '{256, 3, 16, 1, 64, 2, 200, 8, 511, 4, 0, 0, 0, 256};
    sizes[10] = $urandom_range(1, 256);
    sizes[11] = $urandom_range(1, 32);
    sizes[12] = $urandom_range(0, 511);

    for (int p = 0; p < PHASES; p++) begin
      write_pool(fla_pkg::LINK_W'(sizes[p]));
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Hold off mid-phase until the block has answered everything.
        if (n == PHASE_LEN / 2) drain();
        gap = burst ? 0 : $urandom_range(0, 8);
        r   = $urandom_range(0, 99);
        if (r < 50 || (r < 92 && held.size() == 0)) begin
          op  = fla_pkg::CMD_ALLOC;
          idx = fla_pkg::IDX_W'($urandom_range(0, 255));
        end else if (r < 92) begin
          op   = fla_pkg::CMD_FREE;
          pick = $urandom_range(0, held.size() - 1);
          idx  = held[pick];
          held.delete(pick);
        end else begin
          // Stray free: often out of range when the pool is not full, else any slot (which may be a double free).
          op = fla_pkg::CMD_FREE;
          if (pool_size < fla_pkg::MAX_SLOTS && $urandom_range(0, 2) != 0) begin
            idx = fla_pkg::IDX_W'($urandom_range(pool_size, 255));
          end else begin
            idx = fla_pkg::IDX_W'($urandom_range(0, 255));
          end
        end
        issue(op, idx, gap);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (open_results != 0) begin
      $error("%0d expected results never arrived", open_results);
    end
    if (fail_count == 0 && open_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
